[design/tscse_pkg.sv]
package tscse_pkg;

	localparam int ROWS_DEF = 10;
	localparam int COLS_DEF = 10;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_NONE  = 8'h00;

	// escape letters
	localparam logic [7:0] ESC_LET_B = 8'h62;
	localparam logic [7:0] ESC_LET_C = 8'h63;
	localparam logic [7:0] ESC_LET_D = 8'h64;
	localparam logic [7:0] ESC_LET_U = 8'h75;
	localparam logic [7:0] ESC_LET_L = 8'h6C;
	localparam logic [7:0] ESC_LET_R = 8'h72;
	localparam logic [7:0] ESC_LET_E = 8'h65;
	localparam logic [7:0] ESC_LET_H = 8'h68;
	localparam logic [7:0] ESC_LET_I = 8'h69;
	localparam logic [7:0] ESC_LET_O = 8'h6F;

	typedef enum logic [1:0] {
		OP_TEXT = 2'd0,
		OP_EOL  = 2'd1,
		OP_READ = 2'd2,
		OP_NEW  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ESC_NORMAL = 3'b001,
		ESC_CARET  = 3'b010,
		ESC_ROW    = 3'b100
	} esc_state_t;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] char_byte;
		logic [3:0] read_row;
		logic [3:0] read_col;
	} item_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [3:0] cursor_row;
		logic [3:0] cursor_col;
		logic       insert_active;
	} result_t;

	// broadcast from the sequencer to every row cell
	typedef struct packed {
		logic       upd;
		logic       clear_all;
		logic       write;
		logic       erase;
		logic       ins;
		logic [3:0] row;
		logic [3:0] col;
		logic [7:0] data;
		logic       rd_en;
		logic [3:0] rd_row;
		logic [3:0] rd_col;
	} cell_cmd_t;

endpackage

[design/tscse_row_cell.sv]
module tscse_row_cell import tscse_pkg::*; #(
	parameter int COLS    = COLS_DEF,
	parameter int ROW_IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  logic [7:0] rd_in,
	output logic [7:0] rd_out
);

	localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

	logic [7:0] row_q [COLS];
	logic [7:0] row_d [COLS];
	logic       hit;
	logic       rd_hit;

	assign hit    = cmd.upd && (cmd.row == 4'(ROW_IDX));
	assign rd_hit = cmd.rd_en && (cmd.rd_row == 4'(ROW_IDX));

	// pass the read beat along the chain, replacing it on a hit
	assign rd_out = rd_hit ? row_q[cmd.rd_col[CW-1:0]] : rd_in;

	always_comb begin
		for (int j = 0; j < COLS; j++) begin
			row_d[j] = row_q[j];
			if (cmd.upd && cmd.clear_all) begin
				row_d[j] = CH_SPACE;
			end else if (hit && cmd.erase) begin
				if (4'(j) >= cmd.col) row_d[j] = CH_SPACE;
			end else if (hit && cmd.write) begin
				if (4'(j) == cmd.col) begin
					row_d[j] = cmd.data;
				end else if (cmd.ins && (4'(j) > cmd.col) && (j > 0)) begin
					// shift right; last column drops
					row_d[j] = row_q[(j > 0) ? j - 1 : 0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < COLS; j++) row_q[j] <= CH_SPACE;
		end else begin
			for (int j = 0; j < COLS; j++) row_q[j] <= row_d[j];
		end
	end

endmodule

[design/text_screen_control_sequence_engine_core.sv]
// channel   direction  handshake                 payload
// item      in         start high, busy low      item_t   (opcode, char, read cell)
// result    out        done high for one cycle   result_t (cell, cursor, mode)
//
// An item is accepted at an edge while busy is low; while busy is then high, the
// row cells apply the update and the read beat runs down the row chain.
// Result and done are registered as busy falls; the next item may be accepted while done is high.
// Reset fills the screen with spaces at once and homes the cursor.
// The receiver cannot stall; done is a strobe.
module text_screen_control_sequence_engine_core import tscse_pkg::*; #(
	parameter int ROWS = ROWS_DEF,
	parameter int COLS = COLS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam logic [3:0] ROW_LAST = 4'(ROWS - 1);
	localparam logic [3:0] COL_LAST = 4'(COLS - 1);

	logic       busy_q;
	logic       done_q;
	item_t      item_s1;
	result_t    res_q;
	logic [3:0] row_q, col_q, pend_q;
	logic       ins_q;
	esc_state_t esc_q;

	logic [3:0] row_n, col_n, pend_n;
	logic       ins_n;
	esc_state_t esc_n;
	logic       put_en;
	logic [7:0] put_data;
	logic       clr;
	logic       ers;
	logic       is_digit;
	logic [3:0] digit;
	logic [7:0] c;
	cell_cmd_t  cmd;
	logic [7:0] rd_chain [ROWS+1];

	assign c        = item_s1.char_byte;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign digit    = 4'(c - CH_ZERO);

	always_comb begin
		row_n    = row_q;
		col_n    = col_q;
		pend_n   = pend_q;
		ins_n    = ins_q;
		esc_n    = esc_q;
		put_en   = 1'b0;
		put_data = c;
		clr      = 1'b0;
		ers      = 1'b0;
		unique case (item_s1.opcode)
			OP_TEXT: begin
				unique case (esc_q)
					ESC_CARET: begin
						esc_n = ESC_NORMAL;
						case (c)
							ESC_LET_B: col_n = '0;
							ESC_LET_C: clr = 1'b1;
							ESC_LET_D: if (row_q < ROW_LAST) row_n = row_q + 4'd1;
							ESC_LET_U: if (row_q != '0) row_n = row_q - 4'd1;
							ESC_LET_L: if (col_q != '0) col_n = col_q - 4'd1;
							ESC_LET_R: if (col_q < COL_LAST) col_n = col_q + 4'd1;
							ESC_LET_E: ers = 1'b1;
							ESC_LET_H: begin
								row_n = '0;
								col_n = '0;
							end
							ESC_LET_I: ins_n = 1'b1;
							ESC_LET_O: ins_n = 1'b0;
							CH_CARET:  put_en = 1'b1;
							default: begin
								if (is_digit) begin
									pend_n = digit;
									esc_n  = ESC_ROW;
								end else begin
									put_en = 1'b1;
								end
							end
						endcase
					end
					ESC_ROW: begin
						esc_n = ESC_NORMAL;
						if (is_digit) begin
							row_n = (pend_q > ROW_LAST) ? ROW_LAST : pend_q;
							col_n = (digit > COL_LAST) ? COL_LAST : digit;
						end else begin
							put_en = 1'b1;
						end
					end
					default: begin
						if (c == CH_CARET) esc_n = ESC_CARET;
						else put_en = 1'b1;
					end
				endcase
			end
			OP_EOL: esc_n = ESC_NORMAL;
			OP_READ: ;
			OP_NEW: begin
				clr    = 1'b1;
				row_n  = '0;
				col_n  = '0;
				ins_n  = 1'b0;
				esc_n  = ESC_NORMAL;
				pend_n = '0;
			end
			default: ;
		endcase
		// advance after a printed character, holding at the last column
		if (put_en && (col_q < COL_LAST)) col_n = col_q + 4'd1;
	end

	always_comb begin
		cmd           = '0;
		cmd.upd       = busy_q;
		cmd.clear_all = clr;
		cmd.write     = put_en;
		cmd.erase     = ers;
		cmd.ins       = ins_q;
		cmd.row       = row_q;
		cmd.col       = col_q;
		cmd.data      = put_data;
		cmd.rd_en     = (item_s1.opcode == OP_READ)
		                && (item_s1.read_row <= ROW_LAST)
		                && (item_s1.read_col <= COL_LAST);
		cmd.rd_row    = item_s1.read_row;
		cmd.rd_col    = item_s1.read_col;
	end

	assign rd_chain[0] = CH_NONE;

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		tscse_row_cell #(
			.COLS   (COLS),
			.ROW_IDX(r)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.rd_in (rd_chain[r]),
			.rd_out(rd_chain[r+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			row_q  <= '0;
			col_q  <= '0;
			pend_q <= '0;
			ins_q  <= 1'b0;
			esc_q  <= ESC_NORMAL;
		end else begin
			busy_q <= start && !busy_q;
			done_q <= busy_q;
			if (busy_q) begin
				row_q  <= row_n;
				col_q  <= col_n;
				pend_q <= pend_n;
				ins_q  <= ins_n;
				esc_q  <= esc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) item_s1 <= item;
		if (busy_q) begin
			res_q.cell_char     <= rd_chain[ROWS];
			res_q.cursor_row    <= row_n;
			res_q.cursor_col    <= col_n;
			res_q.insert_active <= ins_n;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = res_q;

endmodule

[verif/tb_top.sv]
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tscse_pkg::*;

	localparam int SCR_ROWS   = ROWS_DEF;
	localparam int SCR_COLS   = COLS_DEF;
	localparam int STALL_MAX  = 1000;
	localparam int N_ITEMS    = 1150;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    done;
	result_t result;

	// shadow screen, cursor and escape decoder
	logic [7:0] scr [SCR_ROWS][SCR_COLS];
	logic [3:0] cur_row;
	logic [3:0] cur_col;
	logic       ins_mode;
	esc_state_t esc_ph;
	logic [3:0] goto_row;

	result_t expected_q [$];
	int      mismatches = 0;
	int      beats_sent = 0;
	int      results_checked = 0;
	int      op_count [4];
	int      stall_cycles = 0;
	bit      idle_on = 1'b1;

	always #5 clk = ~clk;

	text_screen_control_sequence_engine_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	function automatic void scr_reset();
		for (int r = 0; r < SCR_ROWS; r++) begin
			for (int k = 0; k < SCR_COLS; k++) scr[r][k] = CH_SPACE;
		end
		cur_row  = '0;
		cur_col  = '0;
		ins_mode = 1'b0;
		esc_ph   = ESC_NORMAL;
		goto_row = '0;
	endfunction

	function automatic void scr_put(logic [7:0] c);
		int r;
		int k;
		int j;
		r = (cur_row < SCR_ROWS) ? int'(cur_row) : SCR_ROWS - 1;
		k = (cur_col < SCR_COLS) ? int'(cur_col) : SCR_COLS - 1;
		// shift the tail of the row right; the last column drops
		if (ins_mode) begin
			for (j = SCR_COLS - 1; j > k; j--) scr[r][j] = scr[r][j - 1];
		end
		scr[r][k] = c;
		if (k < SCR_COLS - 1) k++;
		cur_row = 4'(r);
		cur_col = 4'(k);
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic void scr_escape(logic [7:0] c);
		int j;
		esc_ph = ESC_NORMAL;
		case (c)
		ESC_LET_B: cur_col = '0;
		ESC_LET_C: begin
			for (int r = 0; r < SCR_ROWS; r++) begin
				for (int k = 0; k < SCR_COLS; k++) scr[r][k] = CH_SPACE;
			end
		end
		ESC_LET_D: if (cur_row < SCR_ROWS - 1) cur_row++;
		ESC_LET_U: if (cur_row > 0) cur_row--;
		ESC_LET_L: if (cur_col > 0) cur_col--;
		ESC_LET_R: if (cur_col < SCR_COLS - 1) cur_col++;
		ESC_LET_E: begin
			for (j = int'(cur_col); j < SCR_COLS; j++) scr[cur_row][j] = CH_SPACE;
		end
		ESC_LET_H: begin
			cur_row = '0;
			cur_col = '0;
		end
		ESC_LET_I: ins_mode = 1'b1;
		ESC_LET_O: ins_mode = 1'b0;
		CH_CARET:  scr_put(CH_CARET);
		default: begin
			if (is_digit(c)) begin
				goto_row = 4'(c - CH_ZERO);
				esc_ph   = ESC_ROW;
			end else begin
				scr_put(c);
			end
		end
		endcase
	endfunction

	function automatic void scr_text(logic [7:0] c);
		logic [3:0] dcol;
		if (esc_ph == ESC_CARET) begin
			scr_escape(c);
		end else if (esc_ph == ESC_ROW) begin
			esc_ph = ESC_NORMAL;
			if (is_digit(c)) begin
				dcol    = 4'(c - CH_ZERO);
				cur_row = (goto_row < SCR_ROWS) ? goto_row : 4'(SCR_ROWS - 1);
				cur_col = (dcol < SCR_COLS) ? dcol : 4'(SCR_COLS - 1);
			end else begin
				// abandoned goto: the byte goes down as text, caret included
				scr_put(c);
			end
		end else if (c == CH_CARET) begin
			esc_ph = ESC_CARET;
		end else begin
			scr_put(c);
		end
	endfunction

	function automatic result_t predict_screen(item_t it);
		result_t r;
		r = '0;
		case (it.opcode)
		OP_TEXT: scr_text(it.char_byte);
		OP_EOL:  esc_ph = ESC_NORMAL;
		OP_READ: begin
			if (it.read_row < SCR_ROWS && it.read_col < SCR_COLS)
				r.cell_char = scr[it.read_row][it.read_col];
		end
		default: scr_reset();
		endcase
		r.cursor_row    = cur_row;
		r.cursor_col    = cur_col;
		r.insert_active = ins_mode;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		if (mismatches < 20)
			$display("%0t ERROR %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// predict on each accepted beat, check each result against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			stall_cycles++;
			if (start && !busy) begin
				expected_q.push_back(predict_screen(item));
				op_count[item.opcode]++;
				stall_cycles = 0;
			end
			if (done) begin
				stall_cycles = 0;
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing expected", result.cell_char, 8'h0);
				end else begin
					want = expected_q.pop_front();
					results_checked++;
					if (result.cell_char !== want.cell_char)
						report_mismatch("cell_char", result.cell_char, want.cell_char);
					if (result.cursor_row !== want.cursor_row)
						report_mismatch("cursor_row", 8'(result.cursor_row), 8'(want.cursor_row));
					if (result.cursor_col !== want.cursor_col)
						report_mismatch("cursor_col", 8'(result.cursor_col), 8'(want.cursor_col));
					if (result.insert_active !== want.insert_active)
						report_mismatch("insert_active", 8'(result.insert_active),
							8'(want.insert_active));
				end
			end
			if (stall_cycles >= STALL_MAX) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					STALL_MAX, expected_q.size());
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	task automatic send_item(input item_t it);
		while (idle_on && $urandom_range(99) < 37) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		beats_sent++;
		@(negedge clk);
	endtask

	function automatic item_t make_item(opcode_t op, logic [7:0] c, logic [3:0] rr,
		logic [3:0] rc);
		item_t it;
		it.opcode    = op;
		it.char_byte = c;
		it.read_row  = rr;
		it.read_col  = rc;
		return it;
	endfunction

	// unused fields carry random values so every bit moves
	task automatic send_text(logic [7:0] c);
		send_item(make_item(OP_TEXT, c, 4'($urandom), 4'($urandom)));
	endtask

	task automatic send_read(logic [3:0] rr, logic [3:0] rc);
		send_item(make_item(OP_READ, 8'($urandom), rr, rc));
	endtask

	task automatic send_eol();
		send_item(make_item(OP_EOL, 8'($urandom), 4'($urandom), 4'($urandom)));
	endtask

	task automatic send_new_screen();
		send_item(make_item(OP_NEW, 8'($urandom), 4'($urandom), 4'($urandom)));
	endtask

	task automatic send_escape(logic [7:0] letter);
		send_text(CH_CARET);
		send_text(letter);
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic test_plain_ops();
		send_read(4'd0, 4'd0);
		send_read(4'hF, 4'hF);
		send_read(4'd10, 4'd0);
		send_read(4'd0, 4'd10);
		send_text(8'hFF);
		send_text(8'h00);
		send_read(4'd0, 4'd1);
		send_eol();
		send_new_screen();
	endtask

	task automatic test_escape_letters();
		send_text("A");
		send_escape(ESC_LET_I);
		send_escape(ESC_LET_B);
		send_text("B");
		send_escape(ESC_LET_R);
		send_escape(ESC_LET_L);
		send_escape(CH_CARET);
		send_escape(ESC_LET_E);
		send_escape(ESC_LET_O);
		send_escape(ESC_LET_D);
		send_escape(ESC_LET_U);
		send_escape(ESC_LET_H);
		send_escape(ESC_LET_C);
	endtask

	task automatic test_escape_corners();
		// goto the far corner, then write and move against the edges
		send_text(CH_CARET);
		send_text(CH_NINE);
		send_text(CH_NINE);
		send_text("Z");
		send_escape(ESC_LET_D);
		// unknown letter falls through as text
		send_escape("z");
		// caret as a goto column is written literally
		send_text(CH_CARET);
		send_text("5");
		send_text(CH_CARET);
		// line end cancels a pending escape
		send_text(CH_CARET);
		send_eol();
		send_text(ESC_LET_H);
		// a read leaves the pending escape alone
		send_text(CH_CARET);
		send_read(4'd9, 4'd9);
		send_text(ESC_LET_H);
	endtask

	function automatic logic [7:0] pick_letter();
		case ($urandom_range(10))
		0:       return ESC_LET_B;
		1:       return ($urandom_range(2) == 0) ? ESC_LET_C : ESC_LET_H;
		2:       return ESC_LET_D;
		3:       return ESC_LET_U;
		4:       return ESC_LET_L;
		5:       return ESC_LET_R;
		6:       return ESC_LET_E;
		7:       return ESC_LET_H;
		8:       return ESC_LET_I;
		9:       return ESC_LET_O;
		default: return CH_CARET;
		endcase
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'(CH_ZERO + $urandom_range(9));
	endfunction

	task automatic test_random_stream(int n_beats, bit with_idle);
		int stop_at;
		int pick;
		stop_at = beats_sent + n_beats;
		idle_on = with_idle;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_text(8'($urandom_range(8'h7E, 8'h20)));
			end else if (pick < 58) begin
				send_escape(pick_letter());
			end else if (pick < 68) begin
				send_text(CH_CARET);
				send_text(pick_digit());
				send_text(pick_digit());
			end else if (pick < 83) begin
				if ($urandom_range(9) == 0) send_read(4'($urandom), 4'($urandom));
				else send_read(4'($urandom_range(9)), 4'($urandom_range(9)));
			end else if (pick < 87) begin
				send_eol();
			end else if (pick < 88) begin
				send_new_screen();
			end else if (pick < 93) begin
				send_text(8'($urandom));
			end else begin
				// broken sequence: caret or goto row, then any byte
				send_text(CH_CARET);
				if ($urandom_range(1)) send_text(pick_digit());
				send_text(($urandom_range(3) == 0) ? CH_CARET : 8'($urandom));
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		scr_reset();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_plain_ops();
		test_escape_letters();
		test_escape_corners();
		test_random_stream(350, 1'b0);
		hold_until_drained();
		test_random_stream(N_ITEMS - beats_sent, 1'b1);

		start <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		if (expected_q.size() != 0)
			report_mismatch("results never delivered", 8'(expected_q.size()), 8'h0);

		$display("covered %0d beats: %0d text, %0d line end, %0d read, %0d new screen",
			beats_sent, op_count[OP_TEXT], op_count[OP_EOL], op_count[OP_READ],
			op_count[OP_NEW]);
		$display("%0d results checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
